// ===== hw/rtl/lbc_pkg.sv =====
// Shared types, widths and codes for the linear block code engine.
// Used by every module of the block; depends on nothing.
package lbc_pkg;

    localparam int WORD_W = 16;
    localparam int SYN_W = 8;
    localparam int LEN_W = 5;
    localparam int ROWS_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    localparam int LBC_MAX_LENGTH = 16;
    localparam int LBC_MAX_PARITY = 8;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd7;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 4'd3;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_CODE_LENGTH = 2'd0;
    localparam logic [1:0] REG_PARITY_ROWS = 2'd1;
    localparam logic [1:0] REG_H_COLS_LOW = 2'd2;
    localparam logic [1:0] REG_H_COLS_HIGH = 2'd3;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ONE_FIXED = 2'd1;
    localparam logic [1:0] ST_TWO_FIXED = 2'd2;
    localparam logic [1:0] ST_UNCORRECTABLE = 2'd3;

    // Settings derived from the configuration registers.
    typedef struct packed {
        logic [WORD_W-1:0] word_mask;
        logic [WORD_W-1:0] data_mask;
        logic [ROWS_W-1:0] data_bits;
        logic [WORD_W-1:0][SYN_W-1:0] cols;
    } lbc_cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [SYN_W-1:0] syndrome;
        logic [1:0] status;
    } lbc_res_t;

endpackage

// ===== hw/rtl/linear_block_encode_syndrome_correct_core.sv =====
// Top level of the linear block code engine: input register, core logic, result register.
// Depends on lbc_pkg, lbc_cfg and lbc_core.
//
// Usage: items enter on in_valid/in_ready with operation and word_in, and
// results leave on out_valid/out_ready with word_out, syndrome and status.
// Encode (operation 0) fills in the parity bits; decode (operation 1) forms
// the syndrome and fixes one or two bits where a column or a column pair
// matches it. The code is set through the APB-style port, by the user only
// while no item is in flight; the block itself does not enforce this.
// pready is always high and writes land on the access cycle. An accepted
// item is loaded into the input register and then passes through the
// encode/decode logic into the result register, from which the receiver
// takes it. Throughput is one item per cycle while the receiver does not
// stall, set by the single result register that takes a new item on the
// same edge the previous one is taken. When the receiver stalls, the
// result holds, one more item waits in the input register, and in_ready
// drops until out_ready returns.
// Reset empties both registers and restores n = 7, r = 3 and a zero matrix.
module linear_block_encode_syndrome_correct_core #(
    parameter int MAX_LENGTH = lbc_pkg::LBC_MAX_LENGTH,
    parameter int MAX_PARITY = lbc_pkg::LBC_MAX_PARITY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lbc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [lbc_pkg::WORD_W-1:0]      word_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lbc_pkg::WORD_W-1:0]      word_out,
    output logic [lbc_pkg::SYN_W-1:0]       syndrome,
    output logic [1:0]                      status
);
    import lbc_pkg::*;

    lbc_cfg_t          cfg;
    lbc_res_t          res;
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              out_valid_reg;
    lbc_res_t          out_res_reg;
    logic              out_load;

    lbc_cfg #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_PARITY (MAX_PARITY)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lbc_core #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_core (
        .cfg       (cfg),
        .operation (s1_op_reg),
        .word_in   (s1_word_reg),
        .res       (res)
    );

    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg <= operation;
            s1_word_reg <= word_in;
        end
        if (out_load && s1_valid_reg)
            out_res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign word_out = out_res_reg.word;
    assign syndrome = out_res_reg.syndrome;
    assign status = out_res_reg.status;

endmodule

// ===== hw/rtl/lbc_cfg.sv =====
// Configuration registers with their APB-style port, and the derived code settings.
// Depends on lbc_pkg.
module lbc_cfg #(
    parameter int MAX_LENGTH = lbc_pkg::LBC_MAX_LENGTH,
    parameter int MAX_PARITY = lbc_pkg::LBC_MAX_PARITY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lbc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output lbc_pkg::lbc_cfg_t               cfg
);
    import lbc_pkg::*;

    logic [LEN_W-1:0]      code_length_reg;
    logic [ROWS_W-1:0]     parity_rows_reg;
    logic [CFG_DATA_W-1:0] h_low_reg;
    logic [CFG_DATA_W-1:0] h_high_reg;
    logic [1:0]            reg_index;
    logic                  wr_en;
    logic [LEN_W-1:0]      len_eff;
    logic [ROWS_W-1:0]     rows_eff;
    logic [LEN_W-1:0]      data_eff;
    logic [SYN_W-1:0]      row_mask;

    assign pready = 1'b1;
    assign reg_index = paddr[4:3];
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= LEN_RESET;
            parity_rows_reg <= ROWS_RESET;
            h_low_reg <= '0;
            h_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_CODE_LENGTH: code_length_reg <= pwdata[LEN_W-1:0];
                REG_PARITY_ROWS: parity_rows_reg <= pwdata[ROWS_W-1:0];
                REG_H_COLS_LOW:  h_low_reg <= pwdata;
                REG_H_COLS_HIGH: h_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_CODE_LENGTH: prdata = CFG_DATA_W'(code_length_reg);
            REG_PARITY_ROWS: prdata = CFG_DATA_W'(parity_rows_reg);
            REG_H_COLS_LOW:  prdata = h_low_reg;
            REG_H_COLS_HIGH: prdata = h_high_reg;
            default:         prdata = '0;
        endcase
    end

    // Out-of-range settings saturate; the row count also stays below the length.
    always_comb
    begin
        if (code_length_reg < LEN_W'(2))
            len_eff = LEN_W'(2);
        else if (code_length_reg > LEN_W'(MAX_LENGTH))
            len_eff = LEN_W'(MAX_LENGTH);
        else
            len_eff = code_length_reg;

        if (parity_rows_reg < ROWS_W'(1))
            rows_eff = ROWS_W'(1);
        else if (parity_rows_reg > ROWS_W'(MAX_PARITY))
            rows_eff = ROWS_W'(MAX_PARITY);
        else
            rows_eff = parity_rows_reg;
        if (LEN_W'(rows_eff) > len_eff - LEN_W'(1))
            rows_eff = ROWS_W'(len_eff - LEN_W'(1));

        data_eff = len_eff - LEN_W'(rows_eff);

        for (int i = 0; i < SYN_W; i++)
            row_mask[i] = (i < int'(rows_eff));
        for (int j = 0; j < WORD_W; j++)
        begin
            cfg.word_mask[j] = (j < int'(len_eff));
            cfg.data_mask[j] = (j < int'(data_eff));
        end
        cfg.data_bits = data_eff[ROWS_W-1:0];
        for (int j = 0; j < WORD_W / 2; j++)
        begin
            cfg.cols[j] = h_low_reg[j*SYN_W +: SYN_W] & row_mask;
            cfg.cols[j + WORD_W / 2] = h_high_reg[j*SYN_W +: SYN_W] & row_mask;
        end
    end

endmodule

// ===== hw/rtl/lbc_core.sv =====
// Combinational encode and syndrome decode of one word against the current code.
// Depends on lbc_pkg.
module lbc_core #(
    parameter int MAX_LENGTH = lbc_pkg::LBC_MAX_LENGTH
) (
    input  lbc_pkg::lbc_cfg_t              cfg,
    input  logic                           operation,
    input  logic [lbc_pkg::WORD_W-1:0]     word_in,
    output lbc_pkg::lbc_res_t              res
);
    import lbc_pkg::*;

    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] data;
    logic [SYN_W-1:0]  par;
    logic [SYN_W-1:0]  syn;
    logic [WORD_W-1:0] enc_word;
    logic [WORD_W-1:0] one_flip;
    logic [WORD_W-1:0] two_flip;
    logic              one_found;
    logic              two_found;

    always_comb
    begin
        word = word_in & cfg.word_mask;
        data = word & cfg.data_mask;
        par = '0;
        syn = '0;
        for (int j = 0; j < MAX_LENGTH; j++)
        begin
            if (data[j])
                par ^= cfg.cols[j];
            if (word[j])
                syn ^= cfg.cols[j];
        end
        enc_word = (data | (WORD_W'(par) << cfg.data_bits)) & cfg.word_mask;

        // The lowest matching column wins, then the first pair in row-major order.
        one_found = 1'b0;
        one_flip = '0;
        for (int j = 0; j < MAX_LENGTH; j++)
        begin
            if (!one_found && cfg.word_mask[j] && cfg.cols[j] == syn)
            begin
                one_found = 1'b1;
                one_flip[j] = 1'b1;
            end
        end
        two_found = 1'b0;
        two_flip = '0;
        for (int i = 0; i < MAX_LENGTH; i++)
        begin
            for (int j = i + 1; j < MAX_LENGTH; j++)
            begin
                if (!two_found && cfg.word_mask[j] && (cfg.cols[i] ^ cfg.cols[j]) == syn)
                begin
                    two_found = 1'b1;
                    two_flip[i] = 1'b1;
                    two_flip[j] = 1'b1;
                end
            end
        end

        if (operation == OP_ENCODE)
        begin
            res.word = enc_word;
            res.syndrome = '0;
            res.status = ST_OK;
        end
        else
        begin
            res.syndrome = syn;
            if (syn == '0)
            begin
                res.word = word;
                res.status = ST_OK;
            end
            else if (one_found)
            begin
                res.word = word ^ one_flip;
                res.status = ST_ONE_FIXED;
            end
            else if (two_found)
            begin
                res.word = word ^ two_flip;
                res.status = ST_TWO_FIXED;
            end
            else
            begin
                res.word = word;
                res.status = ST_UNCORRECTABLE;
            end
        end
    end

endmodule

// ===== hw/rtl/lbc_checker.sv =====
// Port-level checks for the linear block code engine, bound to its top level.
// Depends on lbc_pkg and linear_block_encode_syndrome_correct_core.
module lbc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lbc_pkg::WORD_W-1:0]  word_out,
    input logic [lbc_pkg::SYN_W-1:0]   syndrome,
    input logic [1:0]                  status
);
    import lbc_pkg::*;

    // A stalled result keeps its fields.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_out)
            && $stable(syndrome) && $stable(status))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a stalled, full output side.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // A zero syndrome always reports a clean word.
    a_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && syndrome == '0 |-> status == ST_OK)
        else $error("zero syndrome with nonzero status");

    // Any correction or failure needs a nonzero syndrome.
    a_fix_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> syndrome != '0)
        else $error("correction reported with zero syndrome");

endmodule

bind linear_block_encode_syndrome_correct_core lbc_checker u_lbc_checker (.*);
